// File: hdl/kelt_pkg.sv
`default_nettype none
package kelt_pkg;

  localparam int SLOTS = 32;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [1:0] OP_NEW  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TICK,
    ST_READ,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic        [1:0]  op;
    logic        [31:0] now;
    logic signed [31:0] light_key;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic        [23:0] start_radius;
    logic        [15:0] lifetime_ms;
    logic        [15:0] decay_rate;
    logic        [9:0]  frame_time;
    logic        [4:0]  slot_index;
  } item_t;

  typedef struct packed {
    logic        [4:0]  slot;
    logic signed [31:0] slot_key;
    logic signed [19:0] out_x;
    logic signed [19:0] out_y;
    logic signed [19:0] out_z;
    logic        [23:0] out_radius;
    logic        [31:0] expiry;
    logic        [5:0]  live_count;
  } result_t;

  typedef struct packed {
    logic        [31:0] key;
    logic        [31:0] expiry;
    logic        [23:0] radius;
    logic        [15:0] decay;
    logic signed [19:0] ox;
    logic signed [19:0] oy;
    logic signed [19:0] oz;
  } entry_t;

endpackage
`default_nettype wire

// File: hdl/keyed_expiring_light_table_core.sv
// A new light or a tick walks the whole slot memory, one slot a cycle, before its result is
// registered; a read or a no-op skips the walk. A new item is taken while the previous result is
// on the ports, but not while busy: the core finishes one item before it takes the next.
// Reset clears all slots at once through per-slot valid bits; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle with done high.
`default_nettype none
module keyed_expiring_light_table_core (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  wire kelt_pkg::item_t item,
  output logic             busy,
  output logic             done,
  output kelt_pkg::result_t result
);
  import kelt_pkg::*;

  entry_t             mem [SLOTS];
  logic [SLOTS-1:0]   valid;
  entry_t             rd_data;
  logic               rd_ok;
  logic [IDX_W-1:0]   rd_addr;

  state_t             state, state_next;
  logic [IDX_W:0]     idx, idx_next;
  item_t              cur, cur_next;
  logic [CNT_W-1:0]   live, live_next;
  logic               found_key, found_key_next;
  logic               found_exp, found_exp_next;
  logic [IDX_W-1:0]   key_slot, key_slot_next;
  logic [IDX_W-1:0]   exp_slot, exp_slot_next;
  logic               key_live, key_live_next;
  logic               exp_live, exp_live_next;
  logic               zero_live, zero_live_next;
  logic               done_next;
  result_t            result_next;

  logic               re;
  logic [IDX_W-1:0]   ra;
  logic               we;
  logic [IDX_W-1:0]   wa;
  entry_t             wd;

  entry_t             e;
  logic               e_live;
  logic               key_hit, exp_hit;
  logic               fk_c, fe_c;
  logic [IDX_W-1:0]   ks_c, es_c;
  logic               kl_c, el_c;
  logic [IDX_W-1:0]   pick;
  logic               pick_live;
  logic [25:0]        prod;
  logic [15:0]        loss;
  logic [23:0]        new_radius;
  logic [5:0]         live_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[wa] <= 1'b1;
    end
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
      rd_ok   <= valid[ra];
      rd_addr <= ra;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      live      <= '0;
      done      <= 1'b0;
      found_key <= 1'b0;
      found_exp <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      live      <= live_next;
      done      <= done_next;
      found_key <= found_key_next;
      found_exp <= found_exp_next;
    end
    cur       <= cur_next;
    key_slot  <= key_slot_next;
    exp_slot  <= exp_slot_next;
    key_live  <= key_live_next;
    exp_live  <= exp_live_next;
    zero_live <= zero_live_next;
    result    <= result_next;
  end

  always_comb begin
    e       = rd_ok ? rd_data : '0;
    e_live  = (e.radius != '0);
    key_hit = (cur.light_key != '0) && (e.key == cur.light_key);
    exp_hit = (e.expiry < cur.now);
    fk_c    = found_key || key_hit;
    fe_c    = found_exp || exp_hit;
    ks_c    = found_key ? key_slot : rd_addr;
    es_c    = found_exp ? exp_slot : rd_addr;
    kl_c    = found_key ? key_live : e_live;
    el_c    = found_exp ? exp_live : e_live;
    if (fk_c) begin
      pick      = ks_c;
      pick_live = kl_c;
    end else if (fe_c) begin
      pick      = es_c;
      pick_live = el_c;
    end else begin
      pick      = '0;
      pick_live = zero_live;
    end
    prod = cur.frame_time * e.decay;
    loss = prod[25:10];
    if (exp_hit) begin
      new_radius = '0;
    end else if (e.radius > 24'(loss)) begin
      new_radius = e.radius - 24'(loss);
    end else begin
      new_radius = '0;
    end
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    cur_next       = cur;
    live_next      = live;
    found_key_next = found_key;
    found_exp_next = found_exp;
    key_slot_next  = key_slot;
    exp_slot_next  = exp_slot;
    key_live_next  = key_live;
    exp_live_next  = exp_live;
    zero_live_next = zero_live;
    done_next      = 1'b0;
    result_next    = result;
    re             = 1'b0;
    ra             = idx[IDX_W-1:0];
    we             = 1'b0;
    wa             = rd_addr;
    wd             = e;
    busy           = (state != ST_IDLE);
    live_sat       = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          cur_next       = item;
          idx_next       = '0;
          found_key_next = 1'b0;
          found_exp_next = 1'b0;
          case (item.op)
            OP_NEW:  state_next = ST_SCAN;
            OP_TICK: state_next = ST_TICK;
            OP_READ: begin
              re         = 1'b1;
              ra         = IDX_W'(item.slot_index);
              state_next = ST_READ;
            end
            default: state_next = ST_FLUSH;
          endcase
        end
      end

      ST_SCAN: begin
        if (idx < (IDX_W + 1)'(SLOTS)) begin
          re = 1'b1;
        end
        if (idx != '0) begin
          found_key_next = fk_c;
          found_exp_next = fe_c;
          key_slot_next  = ks_c;
          exp_slot_next  = es_c;
          key_live_next  = kl_c;
          exp_live_next  = el_c;
          if (rd_addr == '0) begin
            zero_live_next = e_live;
          end
        end
        idx_next = idx + 1'b1;
        if (idx == (IDX_W + 1)'(SLOTS)) begin
          we        = 1'b1;
          wa        = pick;
          wd.key    = cur.light_key;
          wd.expiry = cur.now + 32'(cur.lifetime_ms);
          wd.radius = cur.start_radius;
          wd.decay  = cur.decay_rate;
          wd.ox     = cur.pos_x;
          wd.oy     = cur.pos_y;
          wd.oz     = cur.pos_z;
          live_next = live - CNT_W'(pick_live) + CNT_W'(cur.start_radius != '0);
          live_sat  = (32'(live_next) > 63) ? 6'd63 : 6'(live_next);
          result_next.slot       = 5'(pick);
          result_next.slot_key   = wd.key;
          result_next.out_x      = wd.ox;
          result_next.out_y      = wd.oy;
          result_next.out_z      = wd.oz;
          result_next.out_radius = wd.radius;
          result_next.expiry     = wd.expiry;
          result_next.live_count = live_sat;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_TICK: begin
        if (idx < (IDX_W + 1)'(SLOTS)) begin
          re = 1'b1;
        end
        if ((idx != '0) && e_live) begin
          we        = 1'b1;
          wd.radius = new_radius;
          if (new_radius == '0) begin
            live_next = live - 1'b1;
          end
        end
        idx_next = idx + 1'b1;
        if (idx == (IDX_W + 1)'(SLOTS)) begin
          live_sat    = (32'(live_next) > 63) ? 6'd63 : 6'(live_next);
          result_next = '0;
          result_next.live_count = live_sat;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_READ: begin
        live_sat = (32'(live) > 63) ? 6'd63 : 6'(live);
        result_next = '0;
        result_next.slot       = cur.slot_index;
        result_next.live_count = live_sat;
        if (32'(cur.slot_index) < SLOTS) begin
          result_next.slot_key   = e.key;
          result_next.out_x      = e.ox;
          result_next.out_y      = e.oy;
          result_next.out_z      = e.oz;
          result_next.out_radius = e.radius;
          result_next.expiry     = e.expiry;
        end
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      ST_FLUSH: begin
        live_sat    = (32'(live) > 63) ? 6'd63 : 6'(live);
        result_next = '0;
        result_next.live_count = live_sat;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire
